// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/ttf_pkg.sv -----
// Package with types, constants and the ratio table of the temperature filter.
package ttf_pkg;
  localparam int RomSize = 106;
  localparam logic signed [7:0] NoSampleB = -8'sd127;

  typedef enum logic [2:0] {
    REG_EWMA_WEIGHT = 3'd0,
    REG_SYS_MIN     = 3'd1,
    REG_SYS_MAX     = 3'd2,
    REG_BATT_ON     = 3'd3,
    REG_BATT_OFF    = 3'd4,
    REG_CASE_ON     = 3'd5,
    REG_CASE_OFF    = 3'd6,
    REG_SPARE       = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SEARCH, ST_FILT, ST_NEXT, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic div_start; // start ratio division for the selected channel
    logic div_step;
    logic srch_start;
    logic srch_step;
    logic filt;      // update filter for the selected channel
    logic chan;      // 0 case, 1 ambient
    logic tick;      // apply fan tick
    logic out_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic in_window;
    logic div_done;
    logic srch_done;
  } stat_t;

  function automatic logic [8:0] rom_val(input logic [6:0] i);
    logic [8:0] v;
    case (i)
      7'd0: v=418; 7'd1: v=415; 7'd2: v=411; 7'd3: v=407; 7'd4: v=403;
      7'd5: v=399; 7'd6: v=395; 7'd7: v=390; 7'd8: v=386; 7'd9: v=381;
      7'd10: v=377; 7'd11: v=372; 7'd12: v=367; 7'd13: v=363; 7'd14: v=358;
      7'd15: v=353; 7'd16: v=348; 7'd17: v=343; 7'd18: v=338; 7'd19: v=333;
      7'd20: v=328; 7'd21: v=322; 7'd22: v=317; 7'd23: v=312; 7'd24: v=307;
      7'd25: v=301; 7'd26: v=296; 7'd27: v=291; 7'd28: v=285; 7'd29: v=280;
      7'd30: v=275; 7'd31: v=269; 7'd32: v=264; 7'd33: v=259; 7'd34: v=254;
      7'd35: v=248; 7'd36: v=243; 7'd37: v=238; 7'd38: v=233; 7'd39: v=228;
      7'd40: v=223; 7'd41: v=218; 7'd42: v=213; 7'd43: v=209; 7'd44: v=204;
      7'd45: v=199; 7'd46: v=195; 7'd47: v=190; 7'd48: v=186; 7'd49: v=181;
      7'd50: v=177; 7'd51: v=173; 7'd52: v=168; 7'd53: v=164; 7'd54: v=160;
      7'd55: v=156; 7'd56: v=153; 7'd57: v=149; 7'd58: v=145; 7'd59: v=141;
      7'd60: v=138; 7'd61: v=134; 7'd62: v=131; 7'd63: v=128; 7'd64: v=124;
      7'd65: v=121; 7'd66: v=118; 7'd67: v=115; 7'd68: v=112; 7'd69: v=109;
      7'd70: v=107; 7'd71: v=104; 7'd72: v=101; 7'd73: v=99; 7'd74: v=96;
      7'd75: v=94; 7'd76: v=91; 7'd77: v=89; 7'd78: v=87; 7'd79: v=84;
      7'd80: v=82; 7'd81: v=80; 7'd82: v=78; 7'd83: v=76; 7'd84: v=74;
      7'd85: v=72; 7'd86: v=70; 7'd87: v=69; 7'd88: v=67; 7'd89: v=65;
      7'd90: v=63; 7'd91: v=62; 7'd92: v=60; 7'd93: v=59; 7'd94: v=57;
      7'd95: v=56; 7'd96: v=54; 7'd97: v=53; 7'd98: v=52; 7'd99: v=50;
      7'd100: v=49; 7'd101: v=48; 7'd102: v=47; 7'd103: v=46; 7'd104: v=45;
      7'd105: v=43;
      default: v = 9'd0;
    endcase
    return v;
  endfunction
endpackage

// ----- rtl/ttf_ctrl.sv -----
// Controller state machine sequencing division, table search and filtering.
module ttf_ctrl import ttf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_busy,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  idle
);
  state_t state_r, state_nxt;
  logic   chan_r, chan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.chan  = chan_r;
    idle      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_NEXT;
          chan_nxt  = 1'b0;
        end
      end
      ST_NEXT: begin
        // Ticks and samples outside the supply window go straight to the result.
        if (stat.is_tick || !stat.in_window) begin
          cmd.tick  = stat.is_tick;
          state_nxt = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SEARCH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (stat.srch_done) state_nxt = ST_FILT;
        else cmd.srch_step = 1'b1;
      end
      ST_FILT: begin
        cmd.filt = 1'b1;
        if (chan_r) begin
          state_nxt = ST_OUT;
        end else begin
          chan_nxt  = 1'b1;
          cmd.chan  = 1'b0;
          state_nxt = ST_NEXT;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/ttf_dp.sv -----
// Datapath: divider, table search, filters, fan hysteresis and result register.
module ttf_dp import ttf_pkg::*; #(
  parameter int TableEntries = 106
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [49:0] in_item,
  input  logic [8:0]  ewma_weight,
  input  logic [15:0] sys_min,
  input  logic [15:0] sys_max,
  input  logic signed [7:0] batt_on,
  input  logic signed [7:0] batt_off,
  input  logic signed [7:0] case_on,
  input  logic signed [7:0] case_off,
  output logic [18:0] res_nxt
);
  localparam int Lim = (TableEntries > RomSize) ? RomSize : TableEntries;
  localparam logic [6:0] LastIdx = 7'(Lim - 1);

  logic [49:0] item_r;
  logic [21:0] rem_r;     // running remainder
  logic [21:0] quo_r;
  logic [21:0] num_r;
  logic [4:0]  cnt_r;
  logic [6:0]  idx_r;
  logic        found_r;
  logic signed [7:0]  temp_r [2];
  logic signed [15:0] acc_r [2];
  logic        fan_r;
  logic        pin_r;
  logic        acc_flag_r;

  logic [15:0] sys;
  logic [11:0] mv;
  logic signed [7:0] batt;
  logic [22:0] trial;
  logic        match;
  logic signed [7:0]  tnew;
  logic signed [15:0] fresh;
  logic [8:0]  w;
  logic signed [26:0] mix;
  logic signed [26:0] mixq;
  logic signed [15:0] accq;
  logic signed [15:0] regq;

  assign sys  = item_r[16:1];
  assign mv   = cmd.chan ? item_r[40:29] : item_r[28:17];
  assign batt = item_r[48:41];

  assign stat.is_tick   = item_r[0];
  assign stat.in_window = (sys > sys_min) && (sys <= sys_max);
  assign stat.div_done  = (cnt_r == 5'd22);
  assign stat.srch_done = found_r || (idx_r >= LastIdx);

  // Restoring division of mv*1000 by the supply, one quotient bit a cycle.
  assign trial = {rem_r, num_r[21]} - {7'd0, sys};
  // Quotient fits 22 bits; compare against table entries at full width.
  assign match = (quo_r <= {13'd0, rom_val(idx_r)}) &&
                 (quo_r >= {13'd0, rom_val(idx_r + 7'd1)});

  assign tnew  = found_r ? $signed(8'(idx_r)) - 8'sd20 : -8'sd20;
  assign fresh = 16'(tnew) <<< 8;
  assign w     = (ewma_weight > 9'd256) ? 9'd256 : ewma_weight;
  assign mix   = $signed({18'd0, w}) * 27'(fresh)
               + $signed(27'd256 - {18'd0, w}) * 27'(acc_r[cmd.chan]);
  // Division by 256 truncating toward zero.
  assign mixq  = (mix < 0) ? -((-mix) >>> 8) : (mix >>> 8);
  assign accq  = 16'(mixq);
  assign regq  = (accq < 0) ? -((-accq) >>> 8) : (accq >>> 8);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= '0;
      num_r <= 22'(mv * 22'd1000);
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[22]) begin
        rem_r <= trial[21:0];
        quo_r <= {quo_r[20:0], 1'b1};
      end else begin
        rem_r <= {rem_r[20:0], num_r[21]};
        quo_r <= {quo_r[20:0], 1'b0};
      end
      num_r <= {num_r[20:0], 1'b0};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.srch_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.srch_step) begin
      if (match) found_r <= 1'b1;
      else idx_r <= idx_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r[0]  <= NoSampleB;
      temp_r[1]  <= NoSampleB;
      acc_r[0]   <= '0;
      acc_r[1]   <= '0;
      fan_r      <= 1'b0;
      pin_r      <= 1'b0;
      acc_flag_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pin_r      <= 1'b0;
        acc_flag_r <= 1'b0;
      end
      if (cmd.filt) begin
        acc_flag_r <= 1'b1;
        if (temp_r[cmd.chan] == NoSampleB) begin
          acc_r[cmd.chan]  <= fresh;
          temp_r[cmd.chan] <= tnew;
        end else begin
          acc_r[cmd.chan]  <= accq;
          temp_r[cmd.chan] <= 8'(regq);
        end
      end
      if (cmd.tick) begin
        if (item_r[49]) begin
          fan_r <= 1'b0;
        end else if (!fan_r) begin
          if (batt >= batt_on || temp_r[0] >= case_on) fan_r <= 1'b1;
        end else begin
          pin_r <= 1'b1;
          if (batt <= batt_off && temp_r[0] <= case_off) fan_r <= 1'b0;
        end
      end
    end
  end

  // Result: case, ambient, fan_enabled, fan_pin, sample_accepted.
  assign res_nxt = {acc_flag_r, pin_r, fan_r, temp_r[1], temp_r[0]};
endmodule

// ----- rtl/thermistor_temp_filter_fan_control.sv -----
// Top level: stream ports, configuration registers, controller and datapath.
// A fan tick or rejected sample passes from idle through ST_NEXT and ST_OUT to its result.
// An accepted sample runs, per channel (case, then ambient), the 22-step divider,
// a search of one table entry a cycle and the filter update.
// One item at a time; the next request is taken once the result is registered.
// Synchronous active-low reset restores register defaults, -127 temps, fan off.
module thermistor_temp_filter_fan_control import ttf_pkg::*; #(
  parameter int TABLE_ENTRIES = 106
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command, sys_millivolts, case_millivolts, ambient_millivolts,
  // battery_temp, shutting_down, zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // case_temp_out, ambient_temp_out, fan_enabled, fan_pin, sample_accepted,
  // zero fill
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  cmd_t  cmd;
  stat_t stat;
  logic  idle;
  logic  in_fire;
  logic [18:0] res_nxt;
  logic [18:0] out_r;
  logic        out_v_r;
  logic [8:0]  w_r;
  logic [15:0] min_r, max_r;
  logic signed [7:0] bon_r, boff_r, con_r, coff_r;
  reg_idx_t    ridx;
  logic        wr;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign ridx = reg_idx_t'(cfg_paddr[4:2]);
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 9'd32; min_r <= 16'd2500; max_r <= 16'd5000;
      bon_r <= 8'sd38; boff_r <= 8'sd37; con_r <= 8'sd55; coff_r <= 8'sd52;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_EWMA_WEIGHT: w_r    <= cfg_pwdata[8:0];
        REG_SYS_MIN:     min_r  <= cfg_pwdata[15:0];
        REG_SYS_MAX:     max_r  <= cfg_pwdata[15:0];
        REG_BATT_ON:     bon_r  <= cfg_pwdata[7:0];
        REG_BATT_OFF:    boff_r <= cfg_pwdata[7:0];
        REG_CASE_ON:     con_r  <= cfg_pwdata[7:0];
        REG_CASE_OFF:    coff_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_EWMA_WEIGHT: cfg_prdata = {23'd0, w_r};
      REG_SYS_MIN:     cfg_prdata = {16'd0, min_r};
      REG_SYS_MAX:     cfg_prdata = {16'd0, max_r};
      REG_BATT_ON:     cfg_prdata = {24'd0, bon_r};
      REG_BATT_OFF:    cfg_prdata = {24'd0, boff_r};
      REG_CASE_ON:     cfg_prdata = {24'd0, con_r};
      REG_CASE_OFF:    cfg_prdata = {24'd0, coff_r};
      default:         cfg_prdata = '0;
    endcase
  end

  ttf_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .out_busy (out_v_r && !out_tready),
    .stat, .cmd, .idle
  );

  ttf_dp #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_item (in_tdata[49:0]),
    .ewma_weight (w_r), .sys_min (min_r), .sys_max (max_r),
    .batt_on (bon_r), .batt_off (boff_r), .case_on (con_r), .case_off (coff_r),
    .res_nxt
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (cmd.out_load) out_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_r};
endmodule

// ----- rtl/ttf_checker.sv -----
// Port-level checker for the temperature filter, bound to the top level.
`include "assert_macros.svh"
module ttf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `CHK_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken while busy")
  `CHK_IMPL(a_pin_sample, clk, rst_n, out_tvalid && out_tdata[18], !out_tdata[17], "fan pin set on a sample result")
  `CHK_IMPL(a_fill_zero, clk, rst_n, out_tvalid, out_tdata[23:19] == 5'd0, "result fill bits not zero")
endmodule

bind thermistor_temp_filter_fan_control ttf_checker u_ttf_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
